// ----- sv/vpfa_pkg.sv -----
package vpfa_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_GRAB  = 2'd1,
    KIND_BLOCK = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_FRAME_CAPACITY  = 1'b0,
    CFG_BLOCKS_TO_READY = 1'b1
  } cfg_idx_e;

  localparam logic [15:0] FRAME_CAPACITY_RST  = 16'd42666;
  localparam logic [3:0]  BLOCKS_TO_READY_RST = 4'd5;
  localparam logic [3:0]  BLOCK_COUNT_MAX     = 4'd15;
  localparam int unsigned FLAG_ERROR_BIT      = 6;
  localparam int unsigned FLAG_EOF_BIT        = 1;
  localparam logic [11:0] MIN_LENGTH          = 12'd2;
  localparam logic [7:0]  MIN_HEADER          = 8'd2;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        frame_done;
    logic        frame_ready;
    logic        resubmit;
    logic [15:0] bytes_stored;
  } result_t;

endpackage

// ----- sv/vpfa_core.sv -----
module vpfa_core
  import vpfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] packet_length_i,
  input  logic        status_bad_i,
  input  logic [15:0] frame_capacity_i,
  input  logic [3:0]  blocks_to_ready_i,
  output result_t     result_o
);

  logic [11:0] byte_position_q, byte_position_d;
  logic [7:0]  header_bytes_q, header_bytes_d;
  logic        skip_packet_q, skip_packet_d;
  logic        end_marker_q, end_marker_d;
  logic        overflowed_q, overflowed_d;
  logic        done_q, done_d;
  logic [15:0] stored_count_q, stored_count_d;
  logic [3:0]  block_count_q, block_count_d;

  always_comb begin
    logic [11:0] pos_next;
    pos_next = byte_position_q + 12'd1;

    byte_position_d = byte_position_q;
    header_bytes_d  = header_bytes_q;
    skip_packet_d   = skip_packet_q;
    end_marker_d    = end_marker_q;
    overflowed_d    = overflowed_q;
    done_d          = done_q;
    stored_count_d  = stored_count_q;
    block_count_d   = block_count_q;

    result_o = '0;

    case (kind_e'(kind_i))
      KIND_BYTE: begin
        if (byte_position_q == 12'd0) begin
          header_bytes_d = data_byte_i;
          end_marker_d   = 1'b0;
          overflowed_d   = 1'b0;
          skip_packet_d  = done_q || status_bad_i || (packet_length_i < MIN_LENGTH) ||
                           (data_byte_i < MIN_HEADER) ||
                           ({4'd0, data_byte_i} > packet_length_i);
        end else if (byte_position_q == 12'd1) begin
          if (!skip_packet_q) begin
            if (data_byte_i[FLAG_ERROR_BIT]) begin
              skip_packet_d = 1'b1;
            end else begin
              end_marker_d = data_byte_i[FLAG_EOF_BIT];
            end
          end
        end else if (!skip_packet_q && (byte_position_q >= {4'd0, header_bytes_q})) begin
          if (stored_count_q < frame_capacity_i) begin
            result_o.write_enable  = 1'b1;
            result_o.write_address = stored_count_q;
            result_o.write_data    = data_byte_i;
            stored_count_d         = stored_count_q + 16'd1;
          end else begin
            overflowed_d = 1'b1;
          end
        end
        if ({1'b0, byte_position_q} + 13'd1 >= {1'b0, packet_length_i}) begin
          if (!skip_packet_d && (overflowed_d || (end_marker_d && stored_count_d != 16'd0))) begin
            done_d = 1'b1;
          end
          byte_position_d = 12'd0;
        end else begin
          byte_position_d = pos_next;
        end
      end
      KIND_GRAB: begin
        byte_position_d = '0;
        header_bytes_d  = '0;
        skip_packet_d   = 1'b0;
        end_marker_d    = 1'b0;
        overflowed_d    = 1'b0;
        done_d          = 1'b0;
        stored_count_d  = '0;
        block_count_d   = '0;
      end
      KIND_BLOCK: begin
        byte_position_d = 12'd0;
        if (!status_bad_i) begin
          if (!done_q) begin
            result_o.resubmit = 1'b1;
          end else if (block_count_q < BLOCK_COUNT_MAX) begin
            block_count_d        = block_count_q + 4'd1;
            result_o.frame_ready = (block_count_d == blocks_to_ready_i);
          end
        end
      end
      default: begin
      end
    endcase

    result_o.frame_done   = done_d;
    result_o.bytes_stored = stored_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_position_q <= '0;
      header_bytes_q  <= '0;
      skip_packet_q   <= 1'b0;
      end_marker_q    <= 1'b0;
      overflowed_q    <= 1'b0;
      done_q          <= 1'b0;
      stored_count_q  <= '0;
      block_count_q   <= '0;
    end else if (accept_i) begin
      byte_position_q <= byte_position_d;
      header_bytes_q  <= header_bytes_d;
      skip_packet_q   <= skip_packet_d;
      end_marker_q    <= end_marker_d;
      overflowed_q    <= overflowed_d;
      done_q          <= done_d;
      stored_count_q  <= stored_count_d;
      block_count_q   <= block_count_d;
    end
  end

endmodule

// ----- sv/video_payload_frame_assembler.sv -----
// channel   handshake                 payload
// -------   -----------------------   --------------------------------------------------
// in        in_valid_i / in_ready_o   kind_i data_byte_i packet_length_i status_bad_i
// out       out_valid_o / out_ready_i write_enable_o write_address_o write_data_o
//                                     frame_done_o frame_ready_o resubmit_o bytes_stored_o
// cfg       cfg_we_i                  cfg_index_i cfg_data_i
//
// one transaction per cycle unless stalled; the result appears the cycle after acceptance
// the header and counter logic sits between the frame state and the result register
// in_ready_o is high when the result register is empty or being drained this cycle
// reset clears all frame state and loads capacity 42666 and block threshold 5
module video_payload_frame_assembler
  import vpfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] packet_length_i,
  input  logic        status_bad_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        write_enable_o,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic        frame_done_o,
  output logic        frame_ready_o,
  output logic        resubmit_o,
  output logic [15:0] bytes_stored_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] frame_capacity_q;
  logic [3:0]  blocks_to_ready_q;
  logic        out_valid_q;
  result_t     result_d, result_q;
  logic        accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_capacity_q  <= FRAME_CAPACITY_RST;
      blocks_to_ready_q <= BLOCKS_TO_READY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_CAPACITY:  frame_capacity_q  <= cfg_data_i;
        CFG_BLOCKS_TO_READY: blocks_to_ready_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  vpfa_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .kind_i            (kind_i),
    .data_byte_i       (data_byte_i),
    .packet_length_i   (packet_length_i),
    .status_bad_i      (status_bad_i),
    .frame_capacity_i  (frame_capacity_q),
    .blocks_to_ready_i (blocks_to_ready_q),
    .result_o          (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = result_q.write_enable;
  assign write_address_o = result_q.write_address;
  assign write_data_o    = result_q.write_data;
  assign frame_done_o    = result_q.frame_done;
  assign frame_ready_o   = result_q.frame_ready;
  assign resubmit_o      = result_q.resubmit;
  assign bytes_stored_o  = result_q.bytes_stored;

endmodule

// ----- bench/frame_assembly_checker.sv -----
`timescale 1ns / 100ps

module frame_assembly_checker
  import vpfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] packet_length_i,
  input  logic        status_bad_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  result_t     result_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o,
  output int          checked_o,
  output int          ready_pulses_o,
  output int          writes_o
);

  logic [15:0] capacity;
  logic [3:0]  ready_threshold;

  logic [11:0] byte_pos;
  logic [7:0]  header_len;
  logic        skip_pkt;
  logic        eof_seen;
  logic        overflow_seen;
  logic        frame_done;
  logic [15:0] stored;
  logic [3:0]  blocks_done;

  result_t     frame_results[$];
  result_t     oldest;
  int          mismatches;
  int          checked_count;
  int          ready_count;
  int          write_count;

  function automatic void clear_frame();
    byte_pos      = '0;
    header_len    = '0;
    skip_pkt      = 1'b0;
    eof_seen      = 1'b0;
    overflow_seen = 1'b0;
    frame_done    = 1'b0;
    stored        = '0;
    blocks_done   = '0;
  endfunction

  function automatic result_t advance_frame(logic [1:0] kind, logic [7:0] data,
                                            logic [11:0] plen, logic bad);
    result_t res;
    res = '0;
    if (kind == KIND_BYTE) begin
      if (byte_pos == 12'd0) begin
        header_len    = data;
        eof_seen      = 1'b0;
        overflow_seen = 1'b0;
        skip_pkt      = frame_done || bad || (plen < MIN_LENGTH) || (data < MIN_HEADER) ||
                        ({4'd0, data} > plen);
      end else if (byte_pos == 12'd1) begin
        if (!skip_pkt) begin
          if (data[FLAG_ERROR_BIT]) begin
            skip_pkt = 1'b1;
          end else begin
            eof_seen = data[FLAG_EOF_BIT];
          end
        end
      end else if (!skip_pkt && (byte_pos >= {4'd0, header_len})) begin
        if (stored < capacity) begin
          res.write_enable  = 1'b1;
          res.write_address = stored;
          res.write_data    = data;
          stored            = stored + 16'd1;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      // packet ends once the next position would reach or pass the length
      if (({1'b0, byte_pos} + 13'd1) >= {1'b0, plen}) begin
        if (!skip_pkt && (overflow_seen || (eof_seen && (stored != 16'd0)))) begin
          frame_done = 1'b1;
        end
        byte_pos = '0;
      end else begin
        byte_pos = byte_pos + 12'd1;
      end
    end else if (kind == KIND_GRAB) begin
      clear_frame();
    end else if (kind == KIND_BLOCK) begin
      byte_pos = '0;
      if (!bad) begin
        if (!frame_done) begin
          res.resubmit = 1'b1;
        end else if (blocks_done < BLOCK_COUNT_MAX) begin
          blocks_done = blocks_done + 4'd1;
          if (blocks_done == ready_threshold) begin
            res.frame_ready = 1'b1;
          end
        end
      end
    end
    res.frame_done   = frame_done;
    res.bytes_stored = stored;
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity        = FRAME_CAPACITY_RST;
      ready_threshold = BLOCKS_TO_READY_RST;
      clear_frame();
      frame_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FRAME_CAPACITY) begin
          capacity = cfg_data_i;
        end else begin
          ready_threshold = cfg_data_i[3:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (frame_results.size() == 0) begin
          $error("result transaction with no input transaction pending");
          mismatches++;
        end else begin
          oldest = frame_results.pop_front();
          check_field("write_enable", 16'(oldest.write_enable), 16'(result_i.write_enable));
          check_field("write_address", oldest.write_address, result_i.write_address);
          check_field("write_data", 16'(oldest.write_data), 16'(result_i.write_data));
          check_field("frame_done", 16'(oldest.frame_done), 16'(result_i.frame_done));
          check_field("frame_ready", 16'(oldest.frame_ready), 16'(result_i.frame_ready));
          check_field("resubmit", 16'(oldest.resubmit), 16'(result_i.resubmit));
          check_field("bytes_stored", oldest.bytes_stored, result_i.bytes_stored);
          checked_count++;
          if (oldest.frame_ready) ready_count++;
          if (oldest.write_enable) write_count++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        frame_results.push_back(advance_frame(kind_i, data_byte_i, packet_length_i,
                                              status_bad_i));
      end
    end
    pending_o      <= frame_results.size();
    errors_o       <= mismatches;
    checked_o      <= checked_count;
    ready_pulses_o <= ready_count;
    writes_o       <= write_count;
  end

endmodule

// ----- bench/tb_video_payload_frame_assembler.sv -----
`timescale 1ns / 100ps

module tb_video_payload_frame_assembler;
  import vpfa_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         NUM_PHASES  = 6;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i          = KIND_BYTE;
  logic [7:0]  data_byte_i     = '0;
  logic [11:0] packet_length_i = '0;
  logic        status_bad_i    = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic        write_enable_o;
  logic [15:0] write_address_o;
  logic [7:0]  write_data_o;
  logic        frame_done_o;
  logic        frame_ready_o;
  logic        resubmit_o;
  logic [15:0] bytes_stored_o;
  logic        cfg_we_i        = 1'b0;
  logic        cfg_index_i     = CFG_FRAME_CAPACITY;
  logic [15:0] cfg_data_i      = '0;

  result_t observed;
  int      pending;
  int      errors;
  int      checked;
  int      ready_pulses;
  int      writes;
  int      items_sent;
  int      gap_pct;
  int      stall_pct;

  assign observed = {write_enable_o, write_address_o, write_data_o, frame_done_o,
                     frame_ready_o, resubmit_o, bytes_stored_o};

  video_payload_frame_assembler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .packet_length_i(packet_length_i),
    .status_bad_i   (status_bad_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .write_enable_o (write_enable_o),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .frame_done_o   (frame_done_o),
    .frame_ready_o  (frame_ready_o),
    .resubmit_o     (resubmit_o),
    .bytes_stored_o (bytes_stored_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  frame_assembly_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .packet_length_i(packet_length_i),
    .status_bad_i   (status_bad_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_i       (observed),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .errors_o       (errors),
    .checked_o      (checked),
    .ready_pulses_o (ready_pulses),
    .writes_o       (writes)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                           input logic [11:0] plen, input logic bad);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    data_byte_i     <= data;
    packet_length_i <= plen;
    status_bad_i    <= bad;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [15:0] cap, input logic [3:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FRAME_CAPACITY;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    cfg_index_i <= CFG_BLOCKS_TO_READY;
    cfg_data_i  <= {12'd0, thr};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_block(input logic bad);
    send_item(KIND_BLOCK, 8'($urandom), 12'($urandom), bad);
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] flags,
                             input logic [11:0] len, input int count, input logic bad);
    for (int i = 0; i < count; i++) begin
      if (i == 0) begin
        send_item(KIND_BYTE, hdr, len, bad);
      end else if (i == 1) begin
        send_item(KIND_BYTE, flags, len, 1'($urandom));
      end else begin
        send_item(KIND_BYTE, 8'($urandom), len, 1'($urandom));
      end
    end
  endtask

  task automatic send_random_packet(input bit cut_short);
    int         hdr_len;
    int         len;
    int         count;
    int         pick;
    logic [7:0] hdr;
    logic [7:0] flags;
    hdr_len = ($urandom_range(99) < 85) ? 2 : $urandom_range(3, 6);
    len     = hdr_len + $urandom_range(0, 12);
    hdr     = 8'(hdr_len);
    pick    = $urandom_range(99);
    if (pick < 3) begin
      hdr = 8'($urandom_range(0, 1));
    end else if (pick < 6) begin
      hdr = 8'(len + $urandom_range(1, 200));
    end else if (pick < 8) begin
      len = $urandom_range(0, 1);
    end
    flags                 = 8'($urandom);
    flags[FLAG_ERROR_BIT] = ($urandom_range(99) < 5);
    flags[FLAG_EOF_BIT]   = ($urandom_range(99) < 25);
    count = (len < 2) ? 1 : len;
    if (cut_short && count > 1) count = $urandom_range(1, count - 1);
    send_packet(hdr, flags, 12'(len), count, $urandom_range(99) < 3);
  endtask

  task automatic run_phase(input int quota, input bit grabs);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_random_packet(1'b0);
      end else if (pick < 78) begin
        send_block($urandom_range(99) < 10);
      end else if (pick < 80) begin
        if (grabs) begin
          send_item(KIND_GRAB, 8'($urandom), 12'($urandom), 1'($urandom));
        end else begin
          send_block(1'b0);
        end
      end else if (pick < 90) begin
        send_random_packet(1'b1);
        send_block(1'($urandom));
      end else if (pick < 96) begin
        // garbage bytes with any length, recovered by an end of block
        repeat ($urandom_range(1, 4)) begin
          send_item(KIND_BYTE, 8'($urandom), 12'($urandom), 1'($urandom));
        end
        send_block(1'($urandom));
      end else begin
        send_item(KIND_UNUSED, 8'($urandom), 12'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [15:0] cap;
    logic [3:0]  thr;
    int          quota;
    bit          grabs;
    items_sent = 0;
    gap_pct    = 18;
    stall_pct  = 77;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(KIND_UNUSED, 8'hFF, 12'hFFF, 1'b1);
    send_packet(8'd2, 8'd0, 12'd3, 3, 1'b0);
    send_item(KIND_BYTE, 8'h00, 12'd0, 1'b0);
    send_packet(8'd4, 8'd0, 12'd3, 3, 1'b0);
    send_packet(8'd2, 8'd1 << FLAG_ERROR_BIT, 12'd3, 3, 1'b0);
    send_packet(8'd2, 8'd1 << FLAG_EOF_BIT, 12'd3, 3, 1'b1);
    send_packet(8'd2, 8'd1 << FLAG_EOF_BIT, 12'd3, 2, 1'b0);
    send_block(1'b0);
    send_packet(8'd2, 8'd1 << FLAG_EOF_BIT, 12'd3, 3, 1'b0);
    send_block(1'b1);
    send_block(1'b0);
    send_item(KIND_BYTE, 8'hFF, 12'hFFF, 1'b0);
    send_block(1'b0);
    send_item(KIND_GRAB, 8'h00, 12'h000, 1'b0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        gap_pct   = 77;
        stall_pct = 18;
      end else if (p == 4) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      grabs = 1'b1;
      case (p)
        0: begin cap = 16'd1;                          thr = 4'd1;  quota = 250; end
        1: begin cap = 16'($urandom_range(3, 40));     thr = 4'($urandom_range(2, 6));
                 quota = 300; end
        2: begin cap = 16'hFFFF; thr = 4'd15; quota = 450; grabs = 1'b0; end
        3: begin cap = 16'($urandom_range(1, 20));     thr = 4'($urandom_range(1, 15));
                 quota = 300; end
        4: begin cap = 16'hFFFF;                       thr = 4'd3;  quota = 250; end
        default: begin cap = 16'd2;                    thr = 4'd15; quota = 250; end
      endcase
      load_settings(cap, thr);
      // the last phase keeps the frame so the capacity may sit below the stored count
      if (p != NUM_PHASES - 1) begin
        send_item(KIND_GRAB, 8'($urandom), 12'($urandom), 1'($urandom));
      end
      run_phase(quota, grabs);
      wait_idle();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d transactions over %0d register settings, %0d results checked",
             items_sent, NUM_PHASES + 1, checked);
    $display("frame memory writes: %0d, frame ready pulses: %0d", writes, ready_pulses);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
